>>> design/calm_pkg.sv
// ----------------------------------------------------------------------------
// calm_pkg: shared types and constants of the chunk audio level meter
// Field widths, register indexes, threshold reset values and level codes.
// ----------------------------------------------------------------------------
package calm_pkg;

	// field and datapath widths
	localparam int SAMPLE_W  = 16;
	localparam int MAG_W     = 16;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int SUM_W     = 40;
	localparam int ROOT_W    = SUM_W / 2;
	localparam int SREM_W    = ROOT_W + 2;
	localparam int TRI_W     = ROOT_W + 2;      // 3 * root
	localparam int MIX_W     = TRI_W + 1;       // 3 * root + peak
	localparam int BLEND_W   = MIX_W - 2;
	localparam int THR_W     = 16;
	localparam int LEVEL_W   = 3;
	localparam int REG_IDX_W = 2;
	localparam int STEP_W    = 6;

	typedef logic [THR_W-1:0]     thr_t;
	typedef logic [LEVEL_W-1:0]   level_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// register indexes
	localparam reg_idx_t REG_THR_ONE   = 2'd0;
	localparam reg_idx_t REG_THR_TWO   = 2'd1;
	localparam reg_idx_t REG_THR_THREE = 2'd2;
	localparam reg_idx_t REG_THR_FOUR  = 2'd3;

	// threshold reset values
	localparam thr_t THR_ONE_RST   = 16'd300;
	localparam thr_t THR_TWO_RST   = 16'd900;
	localparam thr_t THR_THREE_RST = 16'd2200;
	localparam thr_t THR_FOUR_RST  = 16'd5000;

	// level codes
	localparam level_t LEVEL_ZERO  = 3'd0;
	localparam level_t LEVEL_ONE   = 3'd1;
	localparam level_t LEVEL_TWO   = 3'd2;
	localparam level_t LEVEL_THREE = 3'd3;
	localparam level_t LEVEL_FOUR  = 3'd4;

endpackage

>>> design/calm_if.sv
// ----------------------------------------------------------------------------
// calm_if: valid/ready channels of the chunk audio level meter
// One interface carries sample words, the other carries level words.
// ----------------------------------------------------------------------------
interface calm_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [calm_pkg::SAMPLE_W-1:0] sample;
	logic                                last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface calm_level_if;
	logic             valid;
	logic             ready;
	calm_pkg::level_t level;

	modport source (output valid, output level, input ready);
	modport sink   (input valid, input level, output ready);
endinterface

>>> design/chunk_audio_level_meter_core.sv
// ----------------------------------------------------------------------------
// chunk_audio_level_meter_core: RMS/peak loudness class of one audio chunk
// Accumulates peak and energy of even-position samples, then runs a serial
// divider and a serial square root to classify the chunk against thresholds.
// ----------------------------------------------------------------------------
// Throughput: one sample word per cycle inside a chunk.
// After the last sample is taken, the level word comes from the 40-step
//   restoring divider (one quotient bit per cycle) and the 20-step square
//   root (one root bit per cycle), then a blend and a classify state; input stalls meanwhile.
// Reset: asynchronous, clears accumulators and handshakes, loads thresholds
//   with 300, 900, 2200 and 5000.
module chunk_audio_level_meter_core #(
	parameter int MAX_CHUNK_SAMPLES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	calm_sample_if.sink        samples,
	calm_level_if.source       levels,
	input  logic               wr_en,
	input  calm_pkg::reg_idx_t wr_index,
	input  calm_pkg::thr_t     wr_data
);
	import calm_pkg::*;

	localparam int USED_LIMIT = (MAX_CHUNK_SAMPLES + 1) / 2;
	localparam int CNT_W      = $clog2(USED_LIMIT + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_SQRT  = 3'd2;
	localparam logic [2:0] ST_BLEND = 3'd3;
	localparam logic [2:0] ST_LEVEL = 3'd4;

	// thresholds
	thr_t thr_one_q, thr_two_q, thr_three_q, thr_four_q;

	// stage 1: magnitude and square
	logic              valid_s1, last_s1;
	logic [MAG_W-1:0]  mag_s1;
	logic [SQ_W-1:0]   sq_s1;

	// chunk accumulators
	logic              odd_q;
	logic [MAG_W-1:0]  peak_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;

	// sequencer and serial datapath
	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  work_q;      // dividend, then quotient, then radicand
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  divisor_q;
	logic [ROOT_W-1:0] root_q;
	logic [SREM_W-1:0] srem_q;
	logic [MAG_W-1:0]  peak_hold_q;
	logic [BLEND_W-1:0] blend_q;

	// output register
	logic              out_valid_q;
	level_t            out_level_q;

	// combinational helpers
	logic              accept;
	logic [MAG_W-1:0]  mag;
	logic              use_smp;
	logic [MAG_W-1:0]  peak_next;
	logic [SUM_W-1:0]  sum_next;
	logic [CNT_W-1:0]  count_next;
	logic [CNT_W:0]    div_trial;
	logic              div_ge;
	logic [CNT_W:0]    div_diff;
	logic [SREM_W+1:0] sq_trial;
	logic [SREM_W+1:0] sq_sub;
	logic              sq_ge;
	logic [SREM_W+1:0] sq_diff;
	logic [MIX_W-1:0]  mix;
	level_t            level_next;
	logic              out_free;

	// input handshake: stall while a chunk end is pending or being worked
	assign samples.ready = (state_q == ST_IDLE) && !(valid_s1 && last_s1);
	assign accept        = samples.valid && samples.ready;

	// magnitude; negating -32768 in 16 bits yields 32768
	assign mag = samples.sample[SAMPLE_W-1]
		? MAG_W'(~unsigned'(samples.sample) + MAG_W'(1))
		: MAG_W'(unsigned'(samples.sample));

	// accumulate step for the word in stage 1
	assign use_smp    = !odd_q && (count_q < CNT_W'(USED_LIMIT));
	assign peak_next  = (use_smp && mag_s1 > peak_q) ? mag_s1 : peak_q;
	assign sum_next   = use_smp ? sum_q + SUM_W'(sq_s1) : sum_q;
	assign count_next = use_smp ? count_q + CNT_W'(1) : count_q;

	// restoring divide step
	assign div_trial = {rem_q, work_q[SUM_W-1]};
	assign div_ge    = div_trial >= {1'b0, divisor_q};
	assign div_diff  = div_trial - {1'b0, divisor_q};

	// square root step: two radicand bits per result bit
	assign sq_trial = {srem_q, work_q[SUM_W-1 -: 2]};
	assign sq_sub   = {2'b00, root_q, 2'b01};
	assign sq_ge    = sq_trial >= sq_sub;
	assign sq_diff  = sq_trial - sq_sub;

	// 3 * rms + peak
	assign mix = MIX_W'({root_q, 1'b0}) + MIX_W'(root_q) + MIX_W'(peak_hold_q);

	// first threshold the blend lies below decides
	always_comb begin
		if (blend_q < BLEND_W'(thr_one_q))
			level_next = LEVEL_ZERO;
		else if (blend_q < BLEND_W'(thr_two_q))
			level_next = LEVEL_ONE;
		else if (blend_q < BLEND_W'(thr_three_q))
			level_next = LEVEL_TWO;
		else if (blend_q < BLEND_W'(thr_four_q))
			level_next = LEVEL_THREE;
		else
			level_next = LEVEL_FOUR;
	end

	assign out_free     = !out_valid_q || levels.ready;
	assign levels.valid = out_valid_q;
	assign levels.level = out_level_q;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_one_q   <= THR_ONE_RST;
			thr_two_q   <= THR_TWO_RST;
			thr_three_q <= THR_THREE_RST;
			thr_four_q  <= THR_FOUR_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_THR_ONE:   thr_one_q   <= wr_data;
				REG_THR_TWO:   thr_two_q   <= wr_data;
				REG_THR_THREE: thr_three_q <= wr_data;
				REG_THR_FOUR:  thr_four_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept)
				last_s1 <= samples.last_sample;
		end
	end

	// stage 1 payload: one 16x16 multiply
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1 <= mag;
			sq_s1  <= mag * mag;
		end
	end

	// accumulators and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_q       <= 1'b0;
			peak_q      <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// level word: load when classified, drop once taken
			if (state_q == ST_LEVEL && out_free)
				out_valid_q <= 1'b1;
			else if (levels.ready)
				out_valid_q <= 1'b0;

			// accumulate; a chunk end hands the totals to the divider
			if (valid_s1) begin
				if (last_s1) begin
					odd_q   <= 1'b0;
					peak_q  <= '0;
					sum_q   <= '0;
					count_q <= '0;
					state_q <= ST_DIV;
					step_q  <= STEP_W'(SUM_W - 1);
				end else begin
					odd_q   <= !odd_q;
					peak_q  <= peak_next;
					sum_q   <= sum_next;
					count_q <= count_next;
				end
			end

			case (state_q)
				ST_IDLE: ;
				ST_DIV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= ST_SQRT;
						step_q  <= STEP_W'(ROOT_W - 1);
					end
				end
				ST_SQRT: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0)
						state_q <= ST_BLEND;
				end
				ST_BLEND: state_q <= ST_LEVEL;
				ST_LEVEL: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// serial divide / root datapath
	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			work_q      <= sum_next;
			divisor_q   <= count_next;
			rem_q       <= '0;
			peak_hold_q <= peak_next;
			root_q      <= '0;
			srem_q      <= '0;
		end else begin
			case (state_q)
				ST_DIV: begin
					rem_q  <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
					work_q <= {work_q[SUM_W-2:0], div_ge};
				end
				ST_SQRT: begin
					srem_q <= sq_ge ? sq_diff[SREM_W-1:0] : sq_trial[SREM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], sq_ge};
					work_q <= {work_q[SUM_W-3:0], 2'b00};
				end
				ST_BLEND: blend_q <= mix[MIX_W-1:2];
				ST_LEVEL: begin
					if (out_free)
						out_level_q <= level_next;
				end
				default: ;
			endcase
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(USED_LIMIT))
		else $error("used count beyond limit");

	a_end_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> (state_q == ST_DIV && step_q == STEP_W'(SUM_W - 1)))
		else $error("chunk end did not start the divider");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_level_q <= LEVEL_FOUR))
		else $error("level word out of range");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the chunk audio level meter
// Drives sample words in chunks, predicts each chunk's level word and checks
// every level word, in order, against the prediction.
// A short table of hand-picked words comes first. Random chunks follow under
// several threshold settings. Both sides insert random gaps, and the level
// side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
	import calm_pkg::*;

	localparam int CHUNK_MAX    = 1024;
	localparam int COUNT_CAP    = (CHUNK_MAX + 1) / 2;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int SETTLE_GAP   = 4;
	localparam int HOLD_AT      = 30;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASES       = 8;
	localparam int PHASE_WORDS  = 106;

	localparam reg_idx_t THR_REGS [4] = '{REG_THR_ONE, REG_THR_TWO, REG_THR_THREE, REG_THR_FOUR};

	typedef enum logic [1:0] {
		ROW_WORD,
		ROW_TYPED,
		ROW_REG
	} row_kind_e;

	typedef struct packed {
		row_kind_e                   kind;
		logic signed [SAMPLE_W-1:0]  sample;
		logic                        last;
		level_t                      level;
		reg_idx_t                    idx;
		thr_t                        data;
	} stim_row_t;

	logic     clk;
	logic     arst_n;
	logic     wr_en;
	reg_idx_t wr_index;
	thr_t     wr_data;

	calm_sample_if sample_bus ();
	calm_level_if  level_bus ();

	chunk_audio_level_meter_core #(
		.MAX_CHUNK_SAMPLES(CHUNK_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (sample_bus),
		.levels   (level_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// meter state as the bench sees it
	thr_t             thr_now [4];
	logic             odd_slot;
	logic [16:0]      peak_mag;
	logic [SUM_W-1:0] energy;
	int unsigned      taken;

	level_t    pending_levels [$];
	stim_row_t stim_table [$];
	int        fail_count;
	int        cycle_count;
	int        phase_words;
	bit        steady;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic void flag_mismatch(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: %s", msg);
	endfunction

	function automatic logic [ROOT_W-1:0] floor_root(logic [SUM_W-1:0] v);
		logic [ROOT_W-1:0] r;
		logic [ROOT_W-1:0] c;
		logic [63:0]       sq;
		r = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			c  = r | (ROOT_W'(1) << b);
			sq = 64'(c) * 64'(c);
			if (sq <= 64'(v))
				r = c;
		end
		return r;
	endfunction

	// fold one sample into the chunk; on the last one, classify and clear
	function automatic void meter_take(input logic signed [SAMPLE_W-1:0] s, input logic last,
			output logic done, output level_t lv);
		logic [16:0]       mag;
		logic [SUM_W-1:0]  mean;
		logic [ROOT_W-1:0] root;
		logic [23:0]       blend;
		done = 1'b0;
		lv   = LEVEL_ZERO;
		if (!odd_slot && taken < COUNT_CAP) begin
			mag = s[SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
			if (mag > peak_mag)
				peak_mag = mag;
			energy = energy + SUM_W'(mag) * SUM_W'(mag);
			taken++;
		end
		if (!last) begin
			odd_slot = ~odd_slot;
			return;
		end
		mean  = energy / SUM_W'(taken);
		root  = floor_root(mean);
		blend = (24'(root) * 24'd3 + 24'(peak_mag)) >> 2;
		// first threshold that the blend lies below decides
		if (blend < 24'(thr_now[REG_THR_ONE]))
			lv = LEVEL_ZERO;
		else if (blend < 24'(thr_now[REG_THR_TWO]))
			lv = LEVEL_ONE;
		else if (blend < 24'(thr_now[REG_THR_THREE]))
			lv = LEVEL_TWO;
		else if (blend < 24'(thr_now[REG_THR_FOUR]))
			lv = LEVEL_THREE;
		else
			lv = LEVEL_FOUR;
		done     = 1'b1;
		odd_slot = 1'b0;
		peak_mag = '0;
		energy   = '0;
		taken    = 0;
	endfunction

	// directed table rows
	function automatic void put_word(logic signed [SAMPLE_W-1:0] s, logic last);
		stim_row_t row;
		row        = '0;
		row.kind   = ROW_WORD;
		row.sample = s;
		row.last   = last;
		stim_table.push_back(row);
	endfunction

	function automatic void put_last(logic signed [SAMPLE_W-1:0] s, level_t lv);
		stim_row_t row;
		row        = '0;
		row.kind   = ROW_TYPED;
		row.sample = s;
		row.last   = 1'b1;
		row.level  = lv;
		stim_table.push_back(row);
	endfunction

	function automatic void put_reg(reg_idx_t idx, thr_t data);
		stim_row_t row;
		row      = '0;
		row.kind = ROW_REG;
		row.idx  = idx;
		row.data = data;
		stim_table.push_back(row);
	endfunction

	// offer one sample word, predict once it is taken
	task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic last,
			input bit typed, input level_t typed_level);
		int     gap;
		logic   done;
		level_t lv;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid       <= 1'b1;
		sample_bus.sample      <= s;
		sample_bus.last_sample <= last;
		do @(posedge clk); while (!sample_bus.ready);
		meter_take(s, last, done, lv);
		if (done)
			pending_levels.push_back(typed ? typed_level : lv);
		phase_words++;
	endtask

	// stop offering and wait until every level word is in
	task automatic settle();
		sample_bus.valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input thr_t data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		thr_now[idx] = data;
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// one chunk; samples from position loud_from on are full scale negative
	task automatic play_chunk(input int len, input int amp, input int loud_from);
		int v;
		for (int i = 0; i < len; i++) begin
			v = int'($urandom_range(0, 2 * amp)) - amp;
			if (v > 32767)
				v = 32767;
			if ($urandom_range(0, 15) == 0)
				v = $urandom_range(0, 1) ? 32767 : -32768;
			if (i >= loud_from)
				v = -32768;
			send_word(SAMPLE_W'(v), i == len - 1, 1'b0, LEVEL_ZERO);
		end
	endtask

	// level side: random stalls, one long hold-off, in-order check
	initial begin
		int     gap;
		int     levels_seen;
		level_t want;
		level_bus.ready <= 1'b0;
		levels_seen = 0;
		wait (arst_n === 1'b1);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 3);
			if (levels_seen == HOLD_AT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				level_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			level_bus.ready <= 1'b1;
			do @(posedge clk); while (!level_bus.valid);
			levels_seen++;
			if (pending_levels.size() == 0) begin
				flag_mismatch($sformatf("level word %0d with none expected", level_bus.level));
			end else begin
				want = pending_levels.pop_front();
				if (level_bus.level !== want)
					flag_mismatch($sformatf("level expected %0d got %0d", want, level_bus.level));
			end
		end
	end

	// stimulus
	initial begin
		int   len;
		int   amp;
		thr_t t [4];
		thr_t swap;
		arst_n                 <= 1'b0;
		wr_en                  <= 1'b0;
		wr_index               <= REG_THR_ONE;
		wr_data                <= '0;
		sample_bus.valid       <= 1'b0;
		sample_bus.sample      <= '0;
		sample_bus.last_sample <= 1'b0;
		fail_count  = 0;
		cycle_count = 0;
		phase_words = 0;
		steady      = 1'b0;
		thr_now[REG_THR_ONE]   = THR_ONE_RST;
		thr_now[REG_THR_TWO]   = THR_TWO_RST;
		thr_now[REG_THR_THREE] = THR_THREE_RST;
		thr_now[REG_THR_FOUR]  = THR_FOUR_RST;
		odd_slot = 1'b0;
		peak_mag = '0;
		energy   = '0;
		taken    = 0;

		// reset-time thresholds; single-sample chunks give blend = magnitude
		put_last(16'sd0, LEVEL_ZERO);
		put_last(-16'sd32768, LEVEL_FOUR);
		put_last(16'sd32767, LEVEL_FOUR);
		// odd position is ignored
		put_word(16'sd0, 1'b0);
		put_last(-16'sd32768, LEVEL_ZERO);
		put_word(16'sd1000, 1'b0);
		put_word(16'sd32767, 1'b0);
		put_last(16'sd1000, LEVEL_TWO);
		// threshold boundaries
		put_last(16'sd300, LEVEL_ONE);
		put_last(16'sd299, LEVEL_ZERO);
		put_last(-16'sd5000, LEVEL_FOUR);
		put_last(16'sd4999, LEVEL_THREE);
		put_last(16'sd2200, LEVEL_THREE);
		put_word(16'sd100, 1'b0);
		put_word(-16'sd1, 1'b0);
		put_word(-16'sd3000, 1'b0);
		put_word(16'sd5, 1'b0);
		put_word(16'sd7, 1'b1);
		// thresholds out of order
		put_reg(REG_THR_ONE, 16'd5000);
		put_reg(REG_THR_TWO, 16'd300);
		put_reg(REG_THR_THREE, 16'd2200);
		put_reg(REG_THR_FOUR, 16'd900);
		put_last(16'sd1000, LEVEL_ZERO);
		put_last(16'sd6000, LEVEL_FOUR);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (stim_table[i]) begin
			case (stim_table[i].kind)
				ROW_REG: begin
					settle();
					write_reg(stim_table[i].idx, stim_table[i].data);
				end
				ROW_TYPED: begin
					send_word(stim_table[i].sample, 1'b1, 1'b1, stim_table[i].level);
				end
				default: begin
					send_word(stim_table[i].sample, stim_table[i].last, 1'b0, LEVEL_ZERO);
				end
			endcase
		end

		// random chunks under a range of threshold settings
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin
					t = '{THR_ONE_RST, THR_TWO_RST, THR_THREE_RST, THR_FOUR_RST};
				end
				1: begin
					t = '{16'd0, 16'd0, 16'd0, 16'd0};
				end
				2: begin
					t = '{16'd32768, 16'd32768, 16'd32768, 16'd32768};
				end
				3: begin
					foreach (t[k])
						t[k] = thr_t'($urandom_range(0, 32768));
				end
				default: begin
					foreach (t[k])
						t[k] = thr_t'($urandom_range(0, 1 << $urandom_range(4, 15)));
					for (int a = 0; a < 3; a++)
						for (int b = 0; b < 3 - a; b++)
							if (t[b] > t[b + 1]) begin
								swap     = t[b];
								t[b]     = t[b + 1];
								t[b + 1] = swap;
							end
				end
			endcase
			foreach (THR_REGS[k])
				write_reg(THR_REGS[k], t[k]);
			steady = (p == 4) ? 1'b1 : ($urandom_range(0, 3) == 0);

			// overlong chunk: loud tail past the count cap must not register
			if (p == 0)
				play_chunk($urandom_range(CHUNK_MAX + 1, CHUNK_MAX + 16), 200, CHUNK_MAX);

			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
				amp = $urandom_range(0, 1 << $urandom_range(0, 15));
				play_chunk(len, amp, len);
			end
		end

		settle();
		steady = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
